### rtl/bocc_pkg.sv
// Shared constants and types for the cross-shaped open/close filter.
// Used by bocc_stage and binary_open_close_cross_filter_unit; no dependencies.
package bocc_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  // Line store per stage: two rows plus two pixels, indexed by sequence number.
  localparam int STORE_DEPTH = 2 * MAX_WIDTH + 2;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int DIM_W       = 11;
  localparam int CNT_W       = $clog2(MAX_WIDTH + 3);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int PIX_W       = 8;

  typedef struct packed {
    logic last;
    logic down;
    logic up;
    logic right;
    logic left;
  } nbr_flags_t;

  // One step of the stream between stages: step marks a slot that carries a
  // transaction (pixel or drain tick), has marks a pixel in that slot.
  typedef struct packed {
    logic             step;
    logic             has;
    logic [PIX_W-1:0] pix;
    nbr_flags_t       flags;
  } step_t;

endpackage

### rtl/binary_open_close_cross_filter_unit.sv
// Cross-shaped opening/closing filter: top level with config registers,
// raster position tracking and the cascade of four stages. Depends on bocc_pkg, bocc_stage.

// Pixels enter one per clock in raster order and pass four cascaded 4-neighbour
// stages (white spread, black spread, black spread, white spread). A transaction
// is accepted every cycle unless a result sits at the output and is not taken;
// a transaction lands in the input register at the accepting edge, then passes
// a write/read register and a compute register in each stage on its way to the
// output register. Each stage
// keeps two 2050-entry line RAMs, one read at the center and right pixel, one at
// the pixels above and below. Results lag the pixel stream by four rows plus
// four pixels; drain ticks (kind = 1) release held pixels of complete frames,
// and a tick with nothing to release gives no result. Write the configuration
// registers only while no transaction is in flight.
module binary_open_close_cross_filter_unit
  import bocc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             kind,
  input  logic [PIX_W-1:0] pixel_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] pixel_out,
  output logic             frame_end,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  localparam int NSTAGES = 4;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WHITE_LEVEL  = 2'd2;
  localparam logic [1:0] REG_BLACK_LEVEL  = 2'd3;

  logic [DIM_W-1:0] frame_width, frame_height;
  logic [PIX_W-1:0] white_level, black_level;
  logic [DIM_W-1:0] eff_w, eff_h;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             at_right, at_bottom;
  logic             en;
  step_t            in_q;
  step_t            link [NSTAGES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(MAX_WIDTH);
      frame_height <= DIM_W'(MAX_HEIGHT);
      white_level  <= '1;
      black_level  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_WHITE_LEVEL:  white_level  <= cfg_data[PIX_W-1:0];
        REG_BLACK_LEVEL:  black_level  <= cfg_data[PIX_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      eff_w = DIM_W'(1);
    end else if (frame_width > DIM_W'(MAX_WIDTH)) begin
      eff_w = DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = frame_width;
    end
    if (frame_height == '0) begin
      eff_h = DIM_W'(1);
    end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
      eff_h = DIM_W'(MAX_HEIGHT);
    end else begin
      eff_h = frame_height;
    end
    at_right  = (DIM_W'(col) + DIM_W'(1)) >= eff_w;
    at_bottom = (DIM_W'(row) + DIM_W'(1)) >= eff_h;
  end

  // Stall the whole cascade only while a result waits at the output.
  assign en       = !(out_valid && !out_ready);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      row         <= '0;
      in_q.step   <= 1'b0;
      in_q.has    <= 1'b0;
    end else if (en) begin
      in_q.step <= in_valid;
      in_q.has  <= in_valid && !kind;
      if (in_valid && !kind) begin
        if (at_right) begin
          col <= '0;
          row <= at_bottom ? '0 : row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
    if (en) begin
      in_q.pix         <= pixel_in;
      in_q.flags.left  <= (col != '0);
      in_q.flags.right <= !at_right;
      in_q.flags.up    <= (row != '0);
      in_q.flags.down  <= !at_bottom;
      in_q.flags.last  <= at_right && at_bottom;
    end
  end

  assign link[0] = in_q;

  for (genvar i = 0; i < NSTAGES; i++) begin : g_stage
    logic [PIX_W-1:0] level;
    if (i == 0 || i == NSTAGES - 1) begin : g_white
      assign level = white_level;
    end else begin : g_black
      assign level = black_level;
    end
    bocc_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .width    (eff_w),
      .level    (level),
      .step_in  (link[i]),
      .step_out (link[i+1])
    );
  end

  assign out_valid = link[NSTAGES].step && link[NSTAGES].has;
  assign pixel_out = link[NSTAGES].pix;
  assign frame_end = link[NSTAGES].flags.last;

endmodule

### rtl/bocc_stage.sv
// One cross-shaped morphology stage: line store, release control, neighbor test.
// Depends on bocc_pkg.
module bocc_stage
  import bocc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [DIM_W-1:0] width,
  input  logic [PIX_W-1:0] level,
  input  step_t            step_in,
  output step_t            step_out
);

  localparam int WORD_W = $bits(nbr_flags_t) + PIX_W;
  localparam int CMP_W  = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(STORE_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(STORE_DEPTH);

  logic [WORD_W-1:0] mem_a [STORE_DEPTH];
  logic [PIX_W-1:0]  mem_b [STORE_DEPTH];

  // Receive/release bookkeeping
  logic [PTR_W-1:0] wp, rp;
  logic [CNT_W-1:0] pend, fc;

  logic             has_in;
  logic [CNT_W-1:0] pend1, fc1;
  logic             rel;
  logic [PTR_W-1:0] wp_inc, rp_inc, addr_u, addr_d;
  logic [PTR_W:0]   up_diff, dn_sum;

  // Read stage registers
  logic [WORD_W-1:0] rd_c;
  logic [PIX_W-1:0]  rd_r, rd_u, rd_d;
  logic              b_step, b_rel;
  logic              hit_c, hit_r, hit_u, hit_d;
  logic [PIX_W-1:0]  wd_pix;
  nbr_flags_t        wd_flags;
  logic [PIX_W-1:0]  left_pix;

  logic [WORD_W-1:0] c_word;
  logic [PIX_W-1:0]  c_pix, r_pix, u_pix, d_pix;
  nbr_flags_t        c_flags;
  logic              spread;

  always_comb begin
    has_in = step_in.step && step_in.has;
    pend1  = pend + CNT_W'(has_in);
    fc1    = (has_in && step_in.flags.last) ? pend1 : fc;
    rel    = step_in.step &&
             ((CMP_W'(pend1) > CMP_W'(width) + CMP_W'(1)) || (fc1 != '0));

    wp_inc = (wp == LAST_PTR) ? '0 : wp + PTR_W'(1);
    rp_inc = (rp == LAST_PTR) ? '0 : rp + PTR_W'(1);

    up_diff = {1'b0, rp} - (PTR_W + 1)'(width);
    addr_u  = up_diff[PTR_W] ? PTR_W'(up_diff + DEPTH_X) : up_diff[PTR_W-1:0];
    dn_sum  = {1'b0, rp} + (PTR_W + 1)'(width);
    addr_d  = (dn_sum >= DEPTH_X) ? PTR_W'(dn_sum - DEPTH_X) : dn_sum[PTR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      rp     <= '0;
      pend   <= '0;
      fc     <= '0;
      b_step <= 1'b0;
      b_rel  <= 1'b0;
    end else if (en) begin
      if (has_in) begin
        wp <= wp_inc;
      end
      if (rel) begin
        rp <= rp_inc;
      end
      pend   <= pend1 - CNT_W'(rel);
      fc     <= (rel && fc1 != '0) ? fc1 - CNT_W'(1) : fc1;
      b_step <= step_in.step;
      b_rel  <= rel;
    end
  end

  // Store the incoming pixel and fetch the window; same-address reads bypass.
  always_ff @(posedge clk) begin
    if (en) begin
      if (has_in) begin
        mem_a[wp] <= {step_in.flags, step_in.pix};
        mem_b[wp] <= step_in.pix;
      end
      rd_c     <= mem_a[rp];
      rd_r     <= mem_a[rp_inc][PIX_W-1:0];
      rd_u     <= mem_b[addr_u];
      rd_d     <= mem_b[addr_d];
      hit_c    <= has_in && (rp == wp);
      hit_r    <= has_in && (rp_inc == wp);
      hit_u    <= has_in && (addr_u == wp);
      hit_d    <= has_in && (addr_d == wp);
      wd_pix   <= step_in.pix;
      wd_flags <= step_in.flags;
    end
  end

  always_comb begin
    c_word  = hit_c ? {wd_flags, wd_pix} : rd_c;
    c_pix   = c_word[PIX_W-1:0];
    c_flags = nbr_flags_t'(c_word[WORD_W-1:PIX_W]);
    r_pix   = hit_r ? wd_pix : rd_r;
    u_pix   = hit_u ? wd_pix : rd_u;
    d_pix   = hit_d ? wd_pix : rd_d;
    spread  = (c_pix == level) ||
              (c_flags.left  && (left_pix == level)) ||
              (c_flags.right && (r_pix == level)) ||
              (c_flags.up    && (u_pix == level)) ||
              (c_flags.down  && (d_pix == level));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_out.step <= 1'b0;
      step_out.has  <= 1'b0;
    end else if (en) begin
      step_out.step <= b_step;
      step_out.has  <= b_step && b_rel;
    end
    // Hold the released center as the left neighbor of the next release.
    if (en) begin
      step_out.pix   <= spread ? level : c_pix;
      step_out.flags <= c_flags;
      if (b_step && b_rel) begin
        left_pix <= c_pix;
      end
    end
  end

  a_flush_within_pending: assert property (@(posedge clk) disable iff (rst)
    fc <= pend)
    else $error("frame flush count exceeds pending pixels");

  a_pending_bounded: assert property (@(posedge clk) disable iff (rst)
    pend <= CNT_W'(MAX_WIDTH + 1))
    else $error("pending pixels exceed one row plus one");

  a_ptr_distance: assert property (@(posedge clk) disable iff (rst)
    ((wp >= rp) ? ({1'b0, wp} - {1'b0, rp}) : ({1'b0, wp} + DEPTH_X - {1'b0, rp}))
      == (PTR_W + 1)'(pend))
    else $error("store pointers disagree with pending count");

endmodule
